>>> rtl/sfp_pkg.sv
// Shared types and constants for the sensor frame parser.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package sfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned HOLD_W      = 32;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned PAYLOAD_LEN = 6;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;
    // (0x55 + 0xAA) mod 256
    localparam logic [BYTE_W-1:0] SUM_SEED    = 8'hFF;

    // Payload positions 2..5 carry the angle and speed bytes
    localparam logic [POS_W-1:0] POS_SKIP       = 3'd0;
    localparam logic [POS_W-1:0] POS_HOLD_FIRST = 3'd2;
    localparam logic [POS_W-1:0] POS_HOLD_LAST  = POS_W'(PAYLOAD_LEN - 1);
    localparam logic [POS_W-1:0] POS_CHECKSUM   = POS_W'(PAYLOAD_LEN);

    typedef enum logic {
        ST_HUNT,
        ST_FRAME
    } t_front_state;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_DATA,
        KIND_LAST
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              shift_hold;
        logic [BYTE_W-1:0] data;
    } t_q_item;

endpackage

`default_nettype wire

>>> rtl/sfp_front.sv
// Front end of the sensor frame parser: sync hunt and byte classification.
// Depends on sfp_pkg; feeds classified requests into sfp_queue.
`default_nettype none

module sfp_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [sfp_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                         i_full,
    output logic                              o_push,
    output sfp_pkg::t_q_item                  o_item
);

    sfp_pkg::t_front_state          r_state, n_state;
    logic [sfp_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [sfp_pkg::BYTE_W-1:0]     r_hist_prev, n_hist_prev;
    logic [sfp_pkg::BYTE_W-1:0]     r_hist_now, n_hist_now;
    logic                           w_accept;

    assign w_accept = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfp_pkg::ST_HUNT;
            r_pos       <= '0;
            r_hist_prev <= '0;
            r_hist_now  <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_hist_prev <= n_hist_prev;
            r_hist_now  <= n_hist_now;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_pos              = r_pos;
        n_hist_prev        = r_hist_prev;
        n_hist_now         = r_hist_now;
        o_push             = 1'b0;
        o_item.kind        = sfp_pkg::KIND_DATA;
        o_item.shift_hold  = 1'b0;
        o_item.data        = i_rx_byte;
        case (r_state)
            sfp_pkg::ST_HUNT: begin
                if (w_accept) begin
                    n_hist_prev = r_hist_now;
                    n_hist_now  = i_rx_byte;
                    if (r_hist_now == sfp_pkg::SYNC_FIRST &&
                        i_rx_byte == sfp_pkg::SYNC_SECOND) begin
                        n_state = sfp_pkg::ST_FRAME;
                        n_pos   = sfp_pkg::POS_SKIP;
                    end
                end
            end
            sfp_pkg::ST_FRAME: begin
                if (w_accept) begin
                    o_push = 1'b1;
                    if (r_pos == sfp_pkg::POS_SKIP) begin
                        // skip byte still enters the sync history
                        n_hist_prev = r_hist_now;
                        n_hist_now  = i_rx_byte;
                        o_item.kind = sfp_pkg::KIND_SKIP;
                        n_pos       = r_pos + 1'b1;
                    end else if (r_pos < sfp_pkg::POS_CHECKSUM) begin
                        o_item.kind       = sfp_pkg::KIND_DATA;
                        o_item.shift_hold = (r_pos >= sfp_pkg::POS_HOLD_FIRST) &&
                                            (r_pos <= sfp_pkg::POS_HOLD_LAST);
                        n_pos             = r_pos + 1'b1;
                    end else begin
                        // checksum byte, or a position past it: close the frame
                        o_item.kind = sfp_pkg::KIND_LAST;
                        n_state     = sfp_pkg::ST_HUNT;
                        n_pos       = sfp_pkg::POS_SKIP;
                    end
                end
            end
            default: begin
                n_state = sfp_pkg::ST_HUNT;
                n_pos   = sfp_pkg::POS_SKIP;
            end
        endcase
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("front pushed into a full queue");

    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.kind == sfp_pkg::KIND_LAST) |=> r_state == sfp_pkg::ST_HUNT)
        else $error("frame did not close after checksum byte");

    a_hunt_pushes_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfp_pkg::ST_HUNT) |-> !o_push)
        else $error("hunt byte was forwarded to the back end");

endmodule

`default_nettype wire

>>> rtl/sfp_queue.sv
// Small register queue holding classified byte requests between front and back.
// Depends on sfp_pkg for the request type.
`default_nettype none

module sfp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sfp_pkg::t_q_item  i_item,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output sfp_pkg::t_q_item       o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sfp_pkg::t_q_item   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> rtl/sfp_back.sv
// Back end of the sensor frame parser: checksum, payload capture and result register.
// Depends on sfp_pkg; drains requests from sfp_queue.
`default_nettype none

module sfp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire sfp_pkg::t_q_item              i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sfp_pkg::VALUE_W-1:0]        o_angle,
    output logic [sfp_pkg::VALUE_W-1:0]        o_speed,
    output logic                               o_frame_ok
);

    logic [sfp_pkg::BYTE_W-1:0]    r_sum, n_sum;
    logic [sfp_pkg::HOLD_W-1:0]    r_hold, n_hold;
    logic [sfp_pkg::VALUE_W-1:0]   r_kept_angle, n_kept_angle;
    logic [sfp_pkg::VALUE_W-1:0]   r_kept_speed, n_kept_speed;
    logic                          r_out_valid, n_out_valid;
    logic                          r_ok, n_ok;
    logic                          w_out_free;
    logic                          w_is_last;

    // result slot frees up when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_last  = (i_head.kind == sfp_pkg::KIND_LAST);
    assign o_pop      = !i_empty && (!w_is_last || w_out_free);

    always_comb begin
        n_sum        = r_sum;
        n_hold       = r_hold;
        n_kept_angle = r_kept_angle;
        n_kept_speed = r_kept_speed;
        n_ok         = r_ok;
        n_out_valid  = r_out_valid && i_stall;
        if (o_pop) begin
            case (i_head.kind)
                sfp_pkg::KIND_SKIP: begin
                    n_sum  = sfp_pkg::SUM_SEED;
                    n_hold = '0;
                end
                sfp_pkg::KIND_DATA: begin
                    n_sum = r_sum + i_head.data;
                    if (i_head.shift_hold) begin
                        n_hold = {r_hold[sfp_pkg::HOLD_W-sfp_pkg::BYTE_W-1:0], i_head.data};
                    end
                end
                sfp_pkg::KIND_LAST: begin
                    n_ok        = (r_sum == i_head.data);
                    n_out_valid = 1'b1;
                    if (r_sum == i_head.data) begin
                        n_kept_angle = r_hold[sfp_pkg::HOLD_W-1:sfp_pkg::VALUE_W];
                        n_kept_speed = r_hold[sfp_pkg::VALUE_W-1:0];
                    end
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_hold       <= '0;
            r_kept_angle <= '0;
            r_kept_speed <= '0;
            r_ok         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_sum        <= n_sum;
            r_hold       <= n_hold;
            r_kept_angle <= n_kept_angle;
            r_kept_speed <= n_kept_speed;
            r_ok         <= n_ok;
            r_out_valid  <= n_out_valid;
        end
    end

    // kept values only move when a checksum byte loads the result slot
    assign o_valid    = r_out_valid;
    assign o_angle    = r_kept_angle;
    assign o_speed    = r_kept_speed;
    assign o_frame_ok = r_ok;

    a_last_needs_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_is_last) |-> w_out_free)
        else $error("frame end drained while result slot was blocked");

    a_kept_moves_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kept_angle != $past(r_kept_angle) || r_kept_speed != $past(r_kept_speed))
            |-> (r_out_valid && r_ok))
        else $error("kept values changed without an accepted frame");

endmodule

`default_nettype wire

>>> rtl/sensor_frame_parser_top.sv
// Sensor frame parser: one received byte per cycle in; angle, speed and frame
// status out at each frame end. The front end hunts for the 0x55 0xAA sync and
// classifies bytes; the back end checks the additive checksum and holds the
// result. A byte is taken every cycle while the request queue between front and
// back has room; the queue only fills when the result register is stalled with a
// frame end waiting behind it. An accepted checksum byte is written into the queue
// and, once it is at the head and the result register is free, loads the result
// register, which then presents the result.
// Angle and speed keep their last accepted values when a frame fails its checksum.
// Depends on sfp_pkg, sfp_front, sfp_queue and sfp_back.
`default_nettype none

module sensor_frame_parser_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [sfp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sfp_pkg::VALUE_W-1:0]        o_angle,
    output logic [sfp_pkg::VALUE_W-1:0]        o_speed,
    output logic                               o_frame_ok
);

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    sfp_pkg::t_q_item   w_push_item;
    sfp_pkg::t_q_item   w_head;

    // hold input whenever the queue is full
    assign o_stall = w_full;

    sfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_angle    (o_angle),
        .o_speed    (o_speed),
        .o_frame_ok (o_frame_ok)
    );

endmodule

`default_nettype wire
